// ----- rtl/trp_pkg.sv -----
// Shared types and constants for the telnet receive parser.
// No dependencies; every other file of the block imports this package.
package trp_pkg;

    // Telnet command and control bytes.
    localparam logic [7:0] BYTE_IAC  = 8'hFF;
    localparam logic [7:0] BYTE_DONT = 8'hFE;
    localparam logic [7:0] BYTE_DO   = 8'hFD;
    localparam logic [7:0] BYTE_WONT = 8'hFC;
    localparam logic [7:0] BYTE_WILL = 8'hFB;
    localparam logic [7:0] BYTE_SB   = 8'hFA;
    localparam logic [7:0] BYTE_SEND = 8'h01;
    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    // Configuration port.
    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_RAW_PASSTHROUGH = 2'd0;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_NEGOTIATE = 2'd1,
        KIND_SB_SEND   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_NORM = 3'd0,
        ST_IAC  = 3'd1,
        ST_CMD  = 3'd2,
        ST_SB   = 3'd3,
        ST_SBC  = 3'd4,
        ST_SBS  = 3'd5,
        ST_SBI  = 3'd6,
        ST_CR   = 3'd7
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [1:0] negotiation_verb;
        logic [7:0] option_code;
    } result_t;

    // Handshake between the parser and the result register.
    typedef struct packed {
        logic    emit;
        result_t result;
    } parse_out_t;

endpackage

// ----- rtl/trp_regs.sv -----
// APB-style configuration register bank for the telnet receive parser.
// Depends on trp_pkg for the address map.
module trp_regs
    import trp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  raw_passthrough
);

    logic raw_passthrough_reg;
    logic raw_passthrough_next;
    logic wr_raw;

    assign pready = 1'b1;
    assign wr_raw = psel && penable && pwrite && (paddr == ADDR_RAW_PASSTHROUGH);

    always_comb
    begin
        raw_passthrough_next = raw_passthrough_reg;
        if (wr_raw)
        begin
            raw_passthrough_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_passthrough_reg <= 1'b0;
        end
        else
        begin
            raw_passthrough_reg <= raw_passthrough_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_RAW_PASSTHROUGH)
        begin
            prdata[0] = raw_passthrough_reg;
        end
    end

    assign raw_passthrough = raw_passthrough_reg;

endmodule

// ----- rtl/trp_in_stage.sv -----
// Input register of the telnet receive parser: holds one received byte.
// Depends on trp_pkg (imported for house consistency of types).
module trp_in_stage
    import trp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       load;

    // The stage takes a new byte when empty or when its byte moves on this cycle.
    assign load     = !in_valid_reg || advance;
    assign rx_stall = !load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = rx_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign held_valid = in_valid_reg;
    assign held_byte  = in_byte_reg;

endmodule

// ----- rtl/trp_parser.sv -----
// Telnet command state machine: state registers plus one pass of next-state logic.
// Depends on trp_pkg for byte codes, state and result types.
module trp_parser
    import trp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] rx_byte,
    input  logic       raw_passthrough,
    output parse_out_t parse_out
);

    parse_state_t parse_state_reg;
    parse_state_t parse_state_next;
    logic [1:0]   pending_verb_reg;
    logic [1:0]   pending_verb_next;
    logic [7:0]   pending_option_reg;
    logic [7:0]   pending_option_next;
    logic         is_verb;

    assign is_verb = (rx_byte >= BYTE_WILL) && (rx_byte <= BYTE_DONT);

    always_comb
    begin
        parse_state_next    = parse_state_reg;
        pending_verb_next   = pending_verb_reg;
        pending_option_next = pending_option_reg;
        parse_out.emit      = 1'b0;
        parse_out.result    = '0;

        if (raw_passthrough)
        begin
            parse_out.emit             = 1'b1;
            parse_out.result.kind      = KIND_DATA;
            parse_out.result.data_byte = rx_byte;
        end
        else
        begin
            case (parse_state_reg)
                ST_IAC:
                begin
                    if (is_verb)
                    begin
                        pending_verb_next = rx_byte[1:0] - BYTE_WILL[1:0];
                        parse_state_next  = ST_CMD;
                    end
                    else if (rx_byte == BYTE_IAC)
                    begin
                        parse_state_next           = ST_NORM;
                        parse_out.emit             = 1'b1;
                        parse_out.result.kind      = KIND_DATA;
                        parse_out.result.data_byte = rx_byte;
                    end
                    else if (rx_byte == BYTE_SB)
                    begin
                        parse_state_next = ST_SB;
                    end
                    else
                    begin
                        parse_state_next = ST_NORM;
                    end
                end
                ST_CMD:
                begin
                    parse_state_next                  = ST_NORM;
                    parse_out.emit                    = 1'b1;
                    parse_out.result.kind             = KIND_NEGOTIATE;
                    parse_out.result.negotiation_verb = pending_verb_reg;
                    parse_out.result.option_code      = rx_byte;
                end
                ST_SB:
                begin
                    pending_option_next = rx_byte;
                    parse_state_next    = ST_SBC;
                end
                ST_SBC:
                begin
                    parse_state_next = (rx_byte == BYTE_SEND) ? ST_SBS : ST_NORM;
                end
                ST_SBS:
                begin
                    parse_state_next = (rx_byte == BYTE_IAC) ? ST_SBI : ST_NORM;
                end
                ST_SBI:
                begin
                    parse_state_next             = ST_NORM;
                    parse_out.emit               = 1'b1;
                    parse_out.result.kind        = KIND_SB_SEND;
                    parse_out.result.option_code = pending_option_reg;
                end
                default:
                begin
                    // Normal data, and the byte after a CR, where only NUL is dropped.
                    if ((parse_state_reg == ST_CR) && (rx_byte == BYTE_NUL))
                    begin
                        parse_state_next = ST_NORM;
                    end
                    else if (rx_byte == BYTE_IAC)
                    begin
                        parse_state_next = ST_IAC;
                    end
                    else
                    begin
                        parse_state_next           = (rx_byte == BYTE_CR) ? ST_CR : ST_NORM;
                        parse_out.emit             = 1'b1;
                        parse_out.result.kind      = KIND_DATA;
                        parse_out.result.data_byte = rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg    <= ST_NORM;
            pending_verb_reg   <= 2'd0;
            pending_option_reg <= 8'd0;
        end
        else if (advance)
        begin
            parse_state_reg    <= parse_state_next;
            pending_verb_reg   <= pending_verb_next;
            pending_option_reg <= pending_option_next;
        end
    end

endmodule

// ----- rtl/trp_out_stage.sv -----
// Result register of the telnet receive parser, driving the result channel.
// Depends on trp_pkg for the parser output struct.
module trp_out_stage
    import trp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  parse_out_t parse_out,
    output logic       free,
    output logic       res_valid,
    input  logic       res_stall,
    output result_t    result
);

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_reg;

    // The register may be overwritten when empty or when its result leaves now.
    assign free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (advance)
        begin
            res_valid_next = parse_out.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && parse_out.emit)
        begin
            res_reg <= parse_out.result;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = res_reg;

endmodule

// ----- rtl/telnet_receive_parser_unit.sv -----
// Telnet receive parser: splits a received byte stream into terminal data and
// telnet negotiation requests.
//
// Receive channel (rx_valid, rx_stall, rx_byte): one network byte per request.
// Result channel (res_valid, res_stall, kind, data_byte, negotiation_verb,
// option_code): zero or one result per received byte, in byte order.
// Configuration: APB-style port with one register, raw_passthrough, at
// address 0; when set every byte is forwarded as data and the parse state holds.
//
// A byte is registered in the input register on acceptance, parsed from there
// by the parse stage, and its result, if any, is registered in the result register.
// One byte per cycle is sustained while res_stall is low; the limit is the single
// parse stage that carries the state register from one byte to the next.
// When res_stall is high with a result waiting, the parse stage holds and
// rx_stall rises once the input register is occupied; nothing is dropped.
// Reset clears both stages, the parse state and the passthrough register.
// Depends on trp_pkg, trp_regs, trp_in_stage, trp_parser and trp_out_stage.
module telnet_receive_parser_unit
    import trp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rx_valid,
    output logic                  rx_stall,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [1:0]            kind,
    output logic [7:0]            data_byte,
    output logic [1:0]            negotiation_verb,
    output logic [7:0]            option_code,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic       raw_passthrough;
    logic       held_valid;
    logic [7:0] held_byte;
    logic       out_free;
    logic       advance;
    parse_out_t parse_out;
    result_t    result;

    assign advance = held_valid && out_free;

    trp_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .raw_passthrough (raw_passthrough)
    );

    trp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    trp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rx_byte         (held_byte),
        .raw_passthrough (raw_passthrough),
        .parse_out       (parse_out)
    );

    trp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .parse_out (parse_out),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .result    (result)
    );

    assign kind             = result.kind;
    assign data_byte        = result.data_byte;
    assign negotiation_verb = result.negotiation_verb;
    assign option_code      = result.option_code;

endmodule

// ----- rtl/trp_checker.sv -----
// Port-level checks for the telnet receive parser, bound to the top level.
// Depends on trp_pkg for the result kind codes.
module trp_checker
    import trp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [1:0] kind,
    input logic [7:0] data_byte,
    input logic [1:0] negotiation_verb,
    input logic [7:0] option_code
);

    // A stalled result stays in place with all of its fields.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(kind) && $stable(data_byte)
            && $stable(negotiation_verb) && $stable(option_code))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (kind == KIND_DATA) || (kind == KIND_NEGOTIATE)
            || (kind == KIND_SB_SEND))
        else $error("result kind out of range");

    // Fields that do not belong to a result kind read as zero.
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_DATA) |-> (negotiation_verb == 2'd0)
            && (option_code == 8'd0))
        else $error("data result carries option fields");

    a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind != KIND_DATA) |-> (data_byte == 8'd0)
            && ((kind == KIND_NEGOTIATE) || (negotiation_verb == 2'd0)))
        else $error("command result carries stray fields");

endmodule

bind telnet_receive_parser_unit trp_checker u_trp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .kind             (kind),
    .data_byte        (data_byte),
    .negotiation_verb (negotiation_verb),
    .option_code      (option_code)
);

// ----- bench/testbench.sv -----
// Testbench for telnet_receive_parser_unit: directed and random byte streams with a
// byte-level predictor, random idling on both channels and a long result hold-off.
// Depends on trp_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench;
    import trp_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  rx_valid = 1'b0;
    logic                  rx_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            data_byte;
    logic [1:0]            negotiation_verb;
    logic [7:0]            option_code;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state, mirroring the block's parse state and configuration.
    parse_state_t parse_st = ST_NORM;
    logic [1:0]   held_verb = 2'd0;
    logic [7:0]   held_option = 8'h00;
    logic         passthrough_cfg = 1'b0;

    result_t expected_results[$];
    int      fail_count = 0;
    bit      idling_on = 1'b1;
    bit      hold_request = 1'b0;

    telnet_receive_parser_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_valid         (rx_valid),
        .rx_stall         (rx_stall),
        .rx_byte          (rx_byte),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .kind             (kind),
        .data_byte        (data_byte),
        .negotiation_verb (negotiation_verb),
        .option_code      (option_code),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 clk = ~clk;

    // Works out the result of one byte and advances the predicted parse state.
    function automatic bit parse_byte(input logic [7:0] c, output result_t r);
        logic [7:0] diff;
        r = '0;
        if (passthrough_cfg)
        begin
            r.kind = KIND_DATA;
            r.data_byte = c;
            return 1'b1;
        end
        case (parse_st)
            ST_IAC:
            begin
                if (c >= BYTE_WILL && c <= BYTE_DONT)
                begin
                    diff = c - BYTE_WILL;
                    held_verb = diff[1:0];
                    parse_st = ST_CMD;
                    return 1'b0;
                end
                if (c == BYTE_IAC)
                begin
                    parse_st = ST_NORM;
                    r.kind = KIND_DATA;
                    r.data_byte = c;
                    return 1'b1;
                end
                if (c == BYTE_SB)
                    parse_st = ST_SB;
                else
                    parse_st = ST_NORM;
                return 1'b0;
            end
            ST_CMD:
            begin
                parse_st = ST_NORM;
                r.kind = KIND_NEGOTIATE;
                r.negotiation_verb = held_verb;
                r.option_code = c;
                return 1'b1;
            end
            ST_SB:
            begin
                held_option = c;
                parse_st = ST_SBC;
                return 1'b0;
            end
            ST_SBC:
            begin
                if (c == BYTE_SEND)
                    parse_st = ST_SBS;
                else
                    parse_st = ST_NORM;
                return 1'b0;
            end
            ST_SBS:
            begin
                if (c == BYTE_IAC)
                    parse_st = ST_SBI;
                else
                    parse_st = ST_NORM;
                return 1'b0;
            end
            ST_SBI:
            begin
                parse_st = ST_NORM;
                r.kind = KIND_SB_SEND;
                r.option_code = held_option;
                return 1'b1;
            end
            ST_CR:
            begin
                if (c == BYTE_NUL)
                begin
                    parse_st = ST_NORM;
                    return 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        // Normal state, and a non-NUL byte after CR.
        if (c == BYTE_IAC)
        begin
            parse_st = ST_IAC;
            return 1'b0;
        end
        if (c == BYTE_CR)
            parse_st = ST_CR;
        else
            parse_st = ST_NORM;
        r.kind = KIND_DATA;
        r.data_byte = c;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one byte and holds it until the block takes the request.
    task automatic send_byte(input logic [7:0] c);
        result_t r;
        int      gap;
        rx_valid <= 1'b1;
        rx_byte  <= c;
        do @(posedge clk); while (rx_stall);
        if (parse_byte(c, r))
            expected_results.push_back(r);
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Bytes that cause no result may still be in the pipeline, hence the extra cycles.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] a,
                              input logic [APB_DATA_W-1:0] d,
                              output logic [APB_DATA_W-1:0] q);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        q = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_passthrough(input logic value);
        logic [APB_DATA_W-1:0] q;
        logic [APB_DATA_W-1:0] d;
        wait_idle();
        d = {31'($urandom()), value};
        apb_access(1'b1, ADDR_RAW_PASSTHROUGH, d, q);
        passthrough_cfg = value;
        apb_access(1'b0, ADDR_RAW_PASSTHROUGH, '0, q);
        if (q !== {{(APB_DATA_W-1){1'b0}}, value})
        begin
            $error("raw_passthrough: expected %0h, actual %0h", value, q);
            fail_count++;
        end
    endtask

    task automatic test_plain_data();
        send_bytes('{8'h00, 8'h7F, 8'h80, BYTE_SB});
        wait_idle();
    endtask

    task automatic test_iac_escape();
        send_bytes('{BYTE_IAC, BYTE_IAC});
        wait_idle();
    endtask

    task automatic test_negotiation();
        send_bytes('{BYTE_IAC, BYTE_WILL, 8'h00, BYTE_IAC, BYTE_DONT, 8'hFF,
                     BYTE_IAC, BYTE_DO, 8'h18});
        wait_idle();
    endtask

    task automatic test_unknown_command();
        send_bytes('{BYTE_IAC, 8'hF0, 8'h41});
        wait_idle();
    endtask

    // One complete send request, then one abandoned at the qualifier and one
    // abandoned for want of IAC after SEND.
    task automatic test_subnegotiation();
        send_bytes('{BYTE_IAC, BYTE_SB, 8'h18, BYTE_SEND, BYTE_IAC, 8'hA5});
        send_bytes('{BYTE_IAC, BYTE_SB, 8'h20, 8'h00, BYTE_IAC, BYTE_SB, 8'h1F,
                     BYTE_SEND, 8'h42});
        wait_idle();
    endtask

    // NUL after CR is removed; IAC after CR still starts a command.
    task automatic test_cr_handling();
        send_bytes('{BYTE_CR, BYTE_NUL, BYTE_CR, BYTE_CR, BYTE_IAC, BYTE_WONT, 8'h01});
        wait_idle();
    endtask

    task automatic test_passthrough();
        set_passthrough(1'b1);
        send_bytes('{BYTE_IAC, BYTE_WILL, BYTE_CR, BYTE_NUL});
        set_passthrough(1'b0);
    endtask

    // The receiver holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        idling_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            send_byte(8'h20 + 8'(i));
        wait_idle();
        idling_on = 1'b1;
    endtask

    task automatic send_random_sequence(output int count);
        int pick;
        pick = $urandom_range(0, 99);
        count = 0;
        if (pick < 33)
        begin
            send_byte(rand_byte());
            count = 1;
        end
        else if (pick < 43)
        begin
            send_byte(BYTE_CR);
            if ($urandom_range(0, 1) != 0)
                send_byte(BYTE_NUL);
            else
                send_byte(rand_byte());
            count = 2;
        end
        else if (pick < 61)
        begin
            send_byte(BYTE_IAC);
            send_byte(BYTE_WILL + 8'($urandom_range(0, 3)));
            send_byte(rand_byte());
            count = 3;
        end
        else if (pick < 74)
        begin
            send_bytes('{BYTE_IAC, BYTE_SB, rand_byte(), BYTE_SEND, BYTE_IAC, rand_byte()});
            count = 6;
        end
        else if (pick < 81)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                send_bytes('{BYTE_IAC, BYTE_SB, rand_byte(), rand_byte()});
                count = 4;
            end
            else
            begin
                send_bytes('{BYTE_IAC, BYTE_SB, rand_byte(), BYTE_SEND,
                             8'($urandom_range(0, 8'hFE))});
                count = 5;
            end
        end
        else if (pick < 87)
        begin
            send_bytes('{BYTE_IAC, BYTE_IAC});
            count = 2;
        end
        else if (pick < 92)
        begin
            send_bytes('{BYTE_IAC, rand_byte()});
            count = 2;
        end
        else
        begin
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++)
                send_byte(rand_byte());
        end
    endtask

    task automatic test_random_stream();
        int sent;
        int n;
        int target;
        for (int phase = 0; phase < 3; phase++)
        begin
            set_passthrough(phase == 1);
            target = (phase == 1) ? 200 : 700;
            sent = 0;
            while (sent < target)
            begin
                if ($urandom_range(0, 39) == 0)
                    idling_on = ($urandom_range(0, 2) != 0);
                send_random_sequence(n);
                sent += n;
            end
        end
        idling_on = 1'b1;
        wait_idle();
    endtask

    // Result side: random stalls, or one long hold-off when asked for.
    initial
    begin : result_side
        int stall_len;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_stall <= 1'b1;
                for (int held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (stall_len - 1) @(posedge clk);
                end
                else
                    res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d data %0h verb %0d option %0h",
                       kind, data_byte, negotiation_verb, option_code);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    fail_count++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, actual %0h", want.data_byte, data_byte);
                    fail_count++;
                end
                if (negotiation_verb !== want.negotiation_verb)
                begin
                    $error("negotiation_verb: expected %0d, actual %0d",
                           want.negotiation_verb, negotiation_verb);
                    fail_count++;
                end
                if (option_code !== want.option_code)
                begin
                    $error("option_code: expected %0h, actual %0h",
                           want.option_code, option_code);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_plain_data();
        test_iac_escape();
        test_negotiation();
        test_unknown_command();
        test_subnegotiation();
        test_cr_handling();
        test_passthrough();
        test_backpressure();
        test_random_stream();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- telnet_receive_parser_unit.f -----
rtl/trp_pkg.sv
rtl/trp_regs.sv
rtl/trp_in_stage.sv
rtl/trp_parser.sv
rtl/trp_out_stage.sv
rtl/telnet_receive_parser_unit.sv
rtl/trp_checker.sv
bench/testbench.sv
